### rtl/kolac_pkg.sv
package kolac_pkg;

	localparam int CW     = 32;          // coordinate width
	localparam int DW     = CW + 1;      // difference / magnitude width
	localparam int KW     = 20;          // tool radius width
	localparam int RW     = CW - 1;      // input radius width
	localparam int SQW    = 2 * CW - 1;  // sum of squares width
	localparam int SQ_ST  = CW;          // square-root stages, one result bit each
	localparam int NW     = KW + DW;     // dividend width
	localparam int DIV_ST = NW;          // divider stages, one quotient bit each
	localparam int LANES  = 6;
	localparam int OW     = NW + 3;      // signed sum width before saturation
	localparam int NORM_MSB = CW - 2;    // normalised magnitude top bit

	localparam logic [1:0] KIND_LINE   = 2'd0;
	localparam logic [1:0] KIND_ARC    = 2'd1;
	localparam logic [1:0] KIND_CIRCLE = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [1:0] COL_RED    = 2'd1;
	localparam logic [1:0] COL_YELLOW = 2'd2;

	localparam logic [1:0] DIR_G2 = 2'b01;
	localparam logic [1:0] DIR_G3 = 2'b10;

	localparam int FLAG_CLOSED = 0;
	localparam int FLAG_CW     = 1;
	localparam int FLAG_CCW    = 2;
	localparam int FLAG_G2     = 3;
	localparam int FLAG_G3     = 4;
	localparam int FLAG_COL_LO = 5;

	typedef struct packed {
		logic [1:0]                kind;
		logic [1:0]                dir;
		logic                      deg;
		logic signed [CW-1:0]      cx;
		logic signed [CW-1:0]      cy;
		logic signed [CW-1:0]      orad;
		logic [LANES-1:0][CW-1:0]  pt;    // sx, sy, ex, ey, mx, my
		logic [LANES-1:0]          neg;
		logic [LANES-1:0][DW-1:0]  mag;
		logic [KW-1:0]             keff;
		logic [CW-1:0]             den;
	} carry_t;

	function automatic logic signed [CW-1:0] sat_coord(input logic signed [OW-1:0] v);
		logic signed [OW-1:0] hi;
		logic signed [OW-1:0] lo;
		hi = OW'(signed'({1'b0, {(CW-1){1'b1}}}));
		lo = -hi - OW'(1);
		if (v > hi)
			return hi[CW-1:0];
		else if (v < lo)
			return lo[CW-1:0];
		else
			return v[CW-1:0];
	endfunction

endpackage

### rtl/kerf_offset_line_arc_circle_top.sv
// Kerf offset of one line, arc or circle per item.
// Pipeline: 5 front stages, 32 square-root stages, 2 multiply stages, 53 divider stages,
// output register.
// Throughput: one item per cycle; a stall on the output freezes the whole pipe.
// Reset (arst_n low, asynchronous): all stage valid bits and tool_radius clear.
module kerf_offset_line_arc_circle_top import kolac_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [KW-1:0]        cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           entity_kind,
	input  logic [6:0]           flags,
	input  logic signed [CW-1:0] center_x,
	input  logic signed [CW-1:0] center_y,
	input  logic [RW-1:0]        radius,
	input  logic signed [CW-1:0] start_x,
	input  logic signed [CW-1:0] start_y,
	input  logic signed [CW-1:0] end_x,
	input  logic signed [CW-1:0] end_y,
	input  logic signed [CW-1:0] mid_x,
	input  logic signed [CW-1:0] mid_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           out_kind,
	output logic [1:0]           out_dir,
	output logic signed [CW-1:0] out_center_x,
	output logic signed [CW-1:0] out_center_y,
	output logic signed [CW-1:0] out_radius,
	output logic signed [CW-1:0] out_start_x,
	output logic signed [CW-1:0] out_start_y,
	output logic signed [CW-1:0] out_end_x,
	output logic signed [CW-1:0] out_end_y,
	output logic signed [CW-1:0] out_mid_x,
	output logic signed [CW-1:0] out_mid_y,
	output logic                 degenerate
);

	logic [KW-1:0] tool_radius_q;
	logic          en;

	// Whole pipe advances together; holds only while a result waits.
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tool_radius_q <= '0;
		else if (cfg_we)
			tool_radius_q <= cfg_wdata;
	end

	// ---------------------------------------------------------------
	// Stage 1: decode, direction, differences, radius update.
	// Items not closed (or of no kind) enter as bubbles.
	// ---------------------------------------------------------------
	carry_t c_s1;
	logic   vld_s1;
	carry_t c1;
	logic   v1;

	always_comb begin
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [DW-1:0] d;
		logic signed [DW-1:0] rsum;
		logic                 pos;
		logic                 negk;
		logic [1:0]           col;
		logic [LANES-1:0][CW-1:0] p;
		logic signed [CW-1:0] c;
		logic                 is_line;
		dx   = DW'(end_x) - DW'(start_x);
		dy   = DW'(end_y) - DW'(start_y);
		col  = flags[FLAG_COL_LO+1:FLAG_COL_LO];
		pos  = 1'b0;
		negk = 1'b0;
		p    = {mid_y, mid_x, end_y, end_x, start_y, start_x};
		is_line = (entity_kind == KIND_LINE);
		c1   = '0;
		v1   = in_valid && flags[FLAG_CLOSED] && (entity_kind != KIND_NONE);
		c1.kind = entity_kind;
		c1.pt   = p;
		case (entity_kind)
			KIND_ARC: begin
				c1.dir = flags[FLAG_G3:FLAG_G2];
				if (flags[FLAG_CW] || flags[FLAG_CCW]) begin
					negk = flags[FLAG_G3];
					pos  = !flags[FLAG_G3] && flags[FLAG_G2];
				end
			end
			KIND_CIRCLE: begin
				c1.dir = (col == COL_RED) ? DIR_G2 : ((col == COL_YELLOW) ? DIR_G3 : 2'b00);
				pos    = (col == COL_RED);
				negk   = (col == COL_YELLOW);
			end
			default: begin
				c1.dir = 2'b00;
			end
		endcase
		if (is_line) begin
			c1.deg    = (dx == '0) && (dy == '0);
			c1.mag[0] = dy[DW-1] ? DW'(-dy) : DW'(dy);
			c1.mag[1] = dx[DW-1] ? DW'(-dx) : DW'(dx);
			c1.neg[0] = !dy[DW-1] && (dy != '0);
			c1.neg[1] = dx[DW-1];
			c1.keff   = c1.deg ? '0 : tool_radius_q;
			c1.den    = '0;
		end else begin
			c1.deg  = (radius == '0);
			c1.cx   = center_x;
			c1.cy   = center_y;
			c1.keff = (!c1.deg && (pos || negk)) ? tool_radius_q : '0;
			c1.den  = c1.deg ? CW'(1) : CW'(radius);
			rsum = DW'(radius) + (pos ? DW'(tool_radius_q) : '0)
				- (negk ? DW'(tool_radius_q) : '0);
			if (c1.deg)
				c1.orad = '0;
			else if (rsum > $signed(DW'({1'b0, {(CW-1){1'b1}}})))
				c1.orad = {1'b0, {(CW-1){1'b1}}};
			else
				c1.orad = rsum[CW-1:0];
			for (int i = 0; i < LANES; i++) begin
				c = (i % 2 == 0) ? center_x : center_y;
				d = DW'($signed(p[i])) - DW'(c);
				c1.mag[i] = d[DW-1] ? DW'(-d) : DW'(d);
				c1.neg[i] = d[DW-1] ^ negk;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= v1;
	end

	always_ff @(posedge clk) begin
		if (en)
			c_s1 <= c1;
	end

	// Stage 2: leading one of the larger line component
	carry_t      c_s2;
	logic        vld_s2;
	logic [5:0]  msb_s2;
	logic [5:0]  msb2;

	always_comb begin
		logic [DW-1:0] big;
		big  = (c_s1.mag[0] > c_s1.mag[1]) ? c_s1.mag[0] : c_s1.mag[1];
		msb2 = '0;
		for (int i = 0; i < DW; i++)
			if (big[i])
				msb2 = 6'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2   <= c_s1;
			msb_s2 <= msb2;
		end
	end

	// Stage 3: normalise line components so the larger sits at the top bit
	carry_t c_s3;
	logic   vld_s3;
	carry_t c3;

	always_comb begin
		c3 = c_s2;
		if (c_s2.kind == KIND_LINE) begin
			for (int i = 0; i < 2; i++) begin
				if (msb_s2 > 6'(NORM_MSB))
					c3.mag[i] = c_s2.mag[i] >> (msb_s2 - 6'(NORM_MSB));
				else
					c3.mag[i] = c_s2.mag[i] << (6'(NORM_MSB) - msb_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en)
			c_s3 <= c3;
	end

	// Stage 4: squares
	carry_t            c_s4;
	logic              vld_s4;
	logic [SQW-2:0]    aa_s4;
	logic [SQW-2:0]    bb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4  <= c_s3;
			aa_s4 <= (SQW-1)'(c_s3.mag[1][CW-2:0]) * (SQW-1)'(c_s3.mag[1][CW-2:0]);
			bb_s4 <= (SQW-1)'(c_s3.mag[0][CW-2:0]) * (SQW-1)'(c_s3.mag[0][CW-2:0]);
		end
	end

	// ---------------------------------------------------------------
	// Square root, one result bit per stage. Entry 0 holds a^2 + b^2.
	// ---------------------------------------------------------------
	carry_t         sq_c   [0:SQ_ST];
	logic           sq_vld [0:SQ_ST];
	logic [SQW-1:0] sq_v   [0:SQ_ST];
	logic [SQW-1:0] sq_r   [0:SQ_ST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sq_vld[0] <= 1'b0;
		else if (en)
			sq_vld[0] <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_c[0] <= c_s4;
			sq_v[0] <= SQW'(aa_s4) + SQW'(bb_s4);
			sq_r[0] <= '0;
		end
	end

	genvar gj;
	generate
		for (gj = 0; gj < SQ_ST; gj++) begin : g_sqrt
			localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 1 - 2 * gj);
			logic [SQW-1:0] t;
			logic [SQW-1:0] v_n;
			logic [SQW-1:0] r_n;

			always_comb begin
				t = sq_r[gj] + BIT;
				if (sq_v[gj] >= t) begin
					v_n = sq_v[gj] - t;
					r_n = (sq_r[gj] >> 1) + BIT;
				end else begin
					v_n = sq_v[gj];
					r_n = sq_r[gj] >> 1;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					sq_vld[gj+1] <= 1'b0;
				else if (en)
					sq_vld[gj+1] <= sq_vld[gj];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					sq_c[gj+1] <= sq_c[gj];
					sq_v[gj+1] <= v_n;
					sq_r[gj+1] <= r_n;
				end
			end
		end
	endgenerate

	// Multiply stage: line length becomes the divisor; k * |d| per lane
	carry_t                    c_m1;
	logic                      vld_m1;
	logic [LANES-1:0][NW-1:0]  prod_m1;
	carry_t                    cm;

	always_comb begin
		cm = sq_c[SQ_ST];
		if (cm.kind == KIND_LINE)
			cm.den = cm.deg ? CW'(1) : sq_r[SQ_ST][CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m1 <= 1'b0;
		else if (en)
			vld_m1 <= sq_vld[SQ_ST];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_m1 <= cm;
			for (int i = 0; i < LANES; i++)
				prod_m1[i] <= NW'(cm.keff) * NW'(cm.mag[i]);
		end
	end

	// ---------------------------------------------------------------
	// Restoring divider, six lanes, one quotient bit per stage.
	// Entry 0 holds k*|d| + den/2 for round-to-nearest.
	// ---------------------------------------------------------------
	carry_t                   dv_c   [0:DIV_ST];
	logic                     dv_vld [0:DIV_ST];
	logic [LANES-1:0][NW-1:0] dv_num [0:DIV_ST];
	logic [LANES-1:0][CW-1:0] dv_rem [0:DIV_ST];
	logic [LANES-1:0][NW-1:0] dv_quo [0:DIV_ST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld[0] <= 1'b0;
		else if (en)
			dv_vld[0] <= vld_m1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_c[0]   <= c_m1;
			dv_rem[0] <= '0;
			dv_quo[0] <= '0;
			for (int i = 0; i < LANES; i++)
				dv_num[0][i] <= prod_m1[i] + NW'(c_m1.den >> 1);
		end
	end

	generate
		for (gj = 0; gj < DIV_ST; gj++) begin : g_div
			logic [LANES-1:0][CW-1:0] rem_n;
			logic [LANES-1:0][NW-1:0] quo_n;

			always_comb begin
				logic [CW:0] r2;
				for (int i = 0; i < LANES; i++) begin
					r2 = {dv_rem[gj][i], dv_num[gj][i][NW-1-gj]};
					if (r2 >= {1'b0, dv_c[gj].den}) begin
						rem_n[i] = CW'(r2 - {1'b0, dv_c[gj].den});
						quo_n[i] = {dv_quo[gj][i][NW-2:0], 1'b1};
					end else begin
						rem_n[i] = r2[CW-1:0];
						quo_n[i] = {dv_quo[gj][i][NW-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					dv_vld[gj+1] <= 1'b0;
				else if (en)
					dv_vld[gj+1] <= dv_vld[gj];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_c[gj+1]   <= dv_c[gj];
					dv_num[gj+1] <= dv_num[gj];
					dv_rem[gj+1] <= rem_n;
					dv_quo[gj+1] <= quo_n;
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------
	// Output stage: apply signed offsets, saturate, mask unused fields.
	// Lines use lane 0 for x and lane 1 for y on both end points.
	// ---------------------------------------------------------------
	carry_t                   cf;
	logic [LANES-1:0][CW-1:0] pf;

	always_comb begin
		logic signed [OW-1:0] off;
		logic [NW-1:0]        q;
		logic                 n;
		int                   ln;
		cf = dv_c[DIV_ST];
		for (int i = 0; i < LANES; i++) begin
			ln  = (cf.kind == KIND_LINE) ? (i % 2) : i;
			q   = dv_quo[DIV_ST][ln];
			n   = cf.neg[ln];
			off = n ? -OW'(q) : OW'(q);
			pf[i] = sat_coord(OW'($signed(cf.pt[i])) + off);
			if ((cf.kind == KIND_LINE && i >= 4) || (cf.kind == KIND_CIRCLE && i >= 2))
				pf[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= dv_vld[DIV_ST];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_kind     <= cf.kind;
			out_dir      <= cf.dir;
			out_center_x <= cf.cx;
			out_center_y <= cf.cy;
			out_radius   <= cf.orad;
			out_start_x  <= pf[0];
			out_start_y  <= pf[1];
			out_end_x    <= pf[2];
			out_end_y    <= pf[3];
			out_mid_x    <= pf[4];
			out_mid_y    <= pf[5];
			degenerate   <= cf.deg;
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import kolac_pkg::*;

	// Item as offered to the block.
	typedef struct {
		logic [1:0]           kind;
		logic [6:0]           flags;
		logic signed [CW-1:0] cx, cy;
		logic [RW-1:0]        rad;
		logic signed [CW-1:0] sx, sy, ex, ey, mx, my;
	} entity_t;

	// One offset entity as it leaves the block.
	typedef struct packed {
		logic [1:0]           kind, dir;
		logic signed [CW-1:0] cx, cy, rad, sx, sy, ex, ey, mx, my;
		logic                 deg;
	} offset_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [KW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] entity_kind = '0;
	logic [6:0] flags = '0;
	logic signed [CW-1:0] center_x = '0, center_y = '0;
	logic [RW-1:0] radius = '0;
	logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic signed [CW-1:0] mid_x = '0, mid_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] out_kind, out_dir;
	logic signed [CW-1:0] out_center_x, out_center_y, out_radius;
	logic signed [CW-1:0] out_start_x, out_start_y, out_end_x, out_end_y;
	logic signed [CW-1:0] out_mid_x, out_mid_y;
	logic degenerate;

	kerf_offset_line_arc_circle_top i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .entity_kind(entity_kind),
		.flags(flags), .center_x(center_x), .center_y(center_y), .radius(radius),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.mid_x(mid_x), .mid_y(mid_y), .out_valid(out_valid), .out_stall(out_stall),
		.out_kind(out_kind), .out_dir(out_dir), .out_center_x(out_center_x),
		.out_center_y(out_center_y), .out_radius(out_radius),
		.out_start_x(out_start_x), .out_start_y(out_start_y),
		.out_end_x(out_end_x), .out_end_y(out_end_y), .out_mid_x(out_mid_x),
		.out_mid_y(out_mid_y), .degenerate(degenerate)
	);

	always #2 clk = ~clk;

	// Predictor's copy of the register.
	logic [KW-1:0] kerf;

	entity_t pending_q[$];   // items waiting for the driver
	offset_t offsets_q[$];   // predicted results, oldest first
	int      mismatches = 0;
	bit      in_idle_ok = 1'b1;   // driver may idle
	bit      in_pause = 1'b0;     // driver offers nothing
	bit      out_idle_ok = 1'b1;  // receiver may stall at random
	int      hold_off = 0;        // receiver blocking stretch, in cycles

	// floor((a*b + den/2)/den), capped at 2^62, as the divider does it.
	function automatic longint unsigned rounded_ratio(longint unsigned a,
			longint unsigned b, longint unsigned den);
		logic [127:0] num;
		logic [127:0] q;
		num = 128'(a) * 128'(b) + 128'(den >> 1);
		q = num / 128'(den);
		if (q > 128'(64'd1 << 62))
			return 64'd1 << 62;
		return q[63:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v -= r + bitv;
				r = (r >> 1) + bitv;
			end else
				r >>= 1;
			bitv >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [CW-1:0] clamp(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[CW-1:0];
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Point moved radially away from (sign>0) or towards the centre.
	function automatic logic signed [CW-1:0] radial_move(longint p, longint c,
			int sgn, longint unsigned r);
		longint d, q;
		d = p - c;
		if (sgn == 0 || d == 0)
			return clamp(p);
		q = rounded_ratio(kerf, magn(d), r);
		if ((d < 0) != (sgn < 0))
			q = -q;
		return clamp(p + q);
	endfunction

	// Offset of one entity; returns 0 when the item gives no result.
	function automatic bit offset_entity(entity_t e, output offset_t o);
		longint dx, dy, ox, oy;
		longint unsigned a, b, big, len, r;
		int sgn;
		logic [1:0] col;
		o = '{default: '0};
		if (!e.flags[FLAG_CLOSED] || e.kind == KIND_NONE)
			return 0;
		o.kind = e.kind;
		if (e.kind == KIND_LINE) begin
			dx = longint'(e.ex) - longint'(e.sx);
			dy = longint'(e.ey) - longint'(e.sy);
			if (dx == 0 && dy == 0) begin
				o.sx = e.sx; o.sy = e.sy; o.ex = e.ex; o.ey = e.ey; o.deg = 1'b1;
				return 1;
			end
			a = magn(dx);
			b = magn(dy);
			big = a > b ? a : b;
			while (big >= (64'd1 << 31)) begin
				a >>= 1; b >>= 1; big >>= 1;
			end
			while (big < (64'd1 << 30)) begin
				a <<= 1; b <<= 1; big <<= 1;
			end
			len = int_sqrt(a * a + b * b);
			ox = rounded_ratio(kerf, b, len);
			oy = rounded_ratio(kerf, a, len);
			if (dy > 0) ox = -ox;
			if (dx < 0) oy = -oy;
			o.sx = clamp(e.sx + ox); o.sy = clamp(e.sy + oy);
			o.ex = clamp(e.ex + ox); o.ey = clamp(e.ey + oy);
			return 1;
		end
		sgn = 0;
		if (e.kind == KIND_ARC) begin
			o.dir = e.flags[FLAG_G3:FLAG_G2];
			if (e.flags[FLAG_CW] || e.flags[FLAG_CCW]) begin
				if (e.flags[FLAG_G3]) sgn = -1;
				else if (e.flags[FLAG_G2]) sgn = 1;
			end
		end else begin
			col = e.flags[FLAG_COL_LO+1:FLAG_COL_LO];
			o.dir = col == COL_RED ? DIR_G2 : (col == COL_YELLOW ? DIR_G3 : 2'b00);
			sgn = col == COL_RED ? 1 : (col == COL_YELLOW ? -1 : 0);
		end
		o.cx = e.cx; o.cy = e.cy;
		r = e.rad;
		if (r == 0) begin
			o.sx = e.sx; o.sy = e.sy;
			if (e.kind == KIND_ARC) begin
				o.ex = e.ex; o.ey = e.ey; o.mx = e.mx; o.my = e.my;
			end
			o.deg = 1'b1;
			return 1;
		end
		o.rad = clamp(longint'(r) + sgn * longint'(kerf));
		o.sx = radial_move(e.sx, e.cx, sgn, r);
		o.sy = radial_move(e.sy, e.cy, sgn, r);
		if (e.kind == KIND_ARC) begin
			o.ex = radial_move(e.ex, e.cx, sgn, r);
			o.ey = radial_move(e.ey, e.cy, sgn, r);
			o.mx = radial_move(e.mx, e.cx, sgn, r);
			o.my = radial_move(e.my, e.cy, sgn, r);
		end
		return 1;
	endfunction

	// Driver: offers the head of the queue, predicts on acceptance.
	always @(posedge clk) begin
		offset_t o;
		entity_t e;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				e = pending_q.pop_front();
				if (offset_entity(e, o))
					offsets_q.push_back(o);
			end
			if (in_valid && in_stall)
				;  // payload held
			else if (!in_pause && pending_q.size() != 0 &&
					(!in_idle_ok || $urandom_range(99) >= 29)) begin
				e = pending_q[0];
				in_valid    <= 1'b1;
				entity_kind <= e.kind;  flags   <= e.flags;
				center_x    <= e.cx;    center_y <= e.cy;  radius <= e.rad;
				start_x     <= e.sx;    start_y <= e.sy;
				end_x       <= e.ex;    end_y   <= e.ey;
				mid_x       <= e.mx;    mid_y   <= e.my;
			end else
				in_valid <= 1'b0;
		end
	end

	// The item at the head is only popped on acceptance, so the one offered
	// next is always pending_q[0] after the pop; the driver reads it then.

	// Monitor and receiver stall control.
	always @(posedge clk) begin
		offset_t x, g;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				g = '{out_kind, out_dir, out_center_x, out_center_y, out_radius,
					out_start_x, out_start_y, out_end_x, out_end_y, out_mid_x,
					out_mid_y, degenerate};
				if (offsets_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result kind %0d", out_kind);
				end else begin
					x = offsets_q.pop_front();
					if (x != g) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", x, g);
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_stall <= 1'b1;
			end else
				out_stall <= out_idle_ok && ($urandom_range(99) < 29);
		end
	end

	function automatic logic signed [CW-1:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed($urandom_range(8191)) - 4096;
			default: return $signed($urandom_range(1 << 24)) - (1 << 23);
		endcase
	endfunction

	function automatic entity_t rnd_entity();
		entity_t e;
		int m;
		m = $urandom_range(2);
		e.kind  = ($urandom_range(19) == 0) ? KIND_NONE : 2'($urandom_range(2));
		e.flags = 7'($urandom());
		if ($urandom_range(9) != 0)
			e.flags[FLAG_CLOSED] = 1'b1;
		e.cx = rnd_coord(m); e.cy = rnd_coord(m);
		case ($urandom_range(5))
			0: e.rad = 31'($urandom());
			1: e.rad = 0;
			default: e.rad = 31'($urandom_range(1 << 22));
		endcase
		e.sx = rnd_coord(m); e.sy = rnd_coord(m);
		e.ex = rnd_coord(m); e.ey = rnd_coord(m);
		e.mx = rnd_coord(m); e.my = rnd_coord(m);
		if ($urandom_range(15) == 0) begin
			e.ex = e.sx; e.ey = e.sy;
		end
		return e;
	endfunction

	task automatic wait_drained();
		while (pending_q.size() != 0 || in_valid || offsets_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_kerf(logic [KW-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		kerf = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic entity_t mk(logic [1:0] k, logic [6:0] f, logic [RW-1:0] r,
			logic signed [CW-1:0] cx, cy, sx, sy, ex, ey);
		entity_t e;
		e = '{k, f, cx, cy, r, sx, sy, ex, ey, sx + ex, sy - ex};
		return e;
	endfunction

	localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
	localparam logic signed [CW-1:0] MINC = 32'sh80000000;

	initial begin
		logic [KW-1:0] kerfs[5];
		kerf = '0;
		kerfs = '{20'h00800, 20'hfffff, 20'd0, 20'd1, 20'h12345};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_kerf(kerfs[0]);
		// Directed: lines, arcs, circles, flags and extremes.
		pending_q.push_back(mk(KIND_LINE, 7'h01, 0, 0, 0, 0, 0, 32'h1000, 0));
		pending_q.push_back(mk(KIND_LINE, 7'h01, 0, 0, 0, 0, 0, 0, -32'sh1000));
		pending_q.push_back(mk(KIND_LINE, 7'h01, 0, 0, 0, MINC, MINC, MAXC, MAXC));
		pending_q.push_back(mk(KIND_LINE, 7'h01, 0, 0, 0, MAXC, 0, MINC, 5));
		pending_q.push_back(mk(KIND_LINE, 7'h01, 0, 0, 0, 7, 9, 7, 9));      // zero length
		pending_q.push_back(mk(KIND_LINE, 7'h00, 0, 0, 0, 0, 0, 5, 5));      // open
		pending_q.push_back(mk(KIND_NONE, 7'h7f, 5, 0, 0, 0, 0, 5, 5));      // kind three
		pending_q.push_back(mk(KIND_ARC, 7'h0b, 31'h4000, 0, 0, 32'h4000, 0, 0, 32'h4000));
		pending_q.push_back(mk(KIND_ARC, 7'h15, 31'h4000, 0, 0, 32'h4000, 0, 0, 32'h4000));
		pending_q.push_back(mk(KIND_ARC, 7'h1f, 31'h4000, 0, 0, -32'sh4000, 0, 0, 32'h4000));
		pending_q.push_back(mk(KIND_ARC, 7'h19, 31'h4000, 0, 0, 32'h4000, 0, 0, 32'h4000));
		pending_q.push_back(mk(KIND_ARC, 7'h03, 31'h4000, 0, 0, 32'h4000, 0, 0, 32'h4000));
		pending_q.push_back(mk(KIND_ARC, 7'h0b, 0, 3, 4, 5, 6, 7, 8));       // zero radius
		pending_q.push_back(mk(KIND_ARC, 7'h0b, 31'h7fffffff, MINC, MAXC, MAXC, MINC, 0, 0));
		pending_q.push_back(mk(KIND_ARC, 7'h0b, 1, MINC, 0, MAXC, MINC, MAXC, 0));
		pending_q.push_back(mk(KIND_CIRCLE, 7'h21, 31'h2000, 0, 0, 32'h2000, 0, 0, 0));
		pending_q.push_back(mk(KIND_CIRCLE, 7'h41, 31'h2000, 0, 0, 0, -32'sh2000, 0, 0));
		pending_q.push_back(mk(KIND_CIRCLE, 7'h61, 31'h2000, 0, 0, 0, 32'h2000, 0, 0));
		pending_q.push_back(mk(KIND_CIRCLE, 7'h01, 31'h2000, 0, 0, 0, 32'h2000, 0, 0));
		pending_q.push_back(mk(KIND_CIRCLE, 7'h21, 0, 1, 2, 3, 4, 5, 6));
		pending_q.push_back(mk(KIND_CIRCLE, 7'h21, 1, MAXC, MAXC, MINC, MINC, 0, 0));
		wait_drained();
		// Random phases under several tool radii.
		for (int p = 0; p < 5; p++) begin
			write_kerf(p == 4 ? 20'($urandom()) : kerfs[p]);
			in_idle_ok  = (p != 2);
			out_idle_ok = (p != 2);
			for (int i = 0; i < 350; i++)
				pending_q.push_back(rnd_entity());
			if (p == 1)
				hold_off = 400;  // pipe fills, input must stall
			if (p == 3) begin
				// sender pauses until every result is back, then goes on
				while (pending_q.size() > 175)
					@(posedge clk);
				in_pause = 1'b1;
				while (offsets_q.size() != 0 || in_valid)
					@(posedge clk);
				in_pause = 1'b0;
			end
			wait_drained();
		end
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
